FILE: rtl/core/buddy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int MaxExp  = 16;
  localparam int MinExp  = 4;
  localparam int IdxW    = MaxExp - MinExp + 1;
  localparam int NodeCnt = (2 ** IdxW) - 1;
  localparam int OffW    = 16;
  localparam int SizeW   = 17;
  localparam int ReqW    = 18;
  localparam int ExpW    = 5;

  localparam logic [ReqW-1:0] ReqLimit = ReqW'(1) << 17;

  // node states
  localparam logic [1:0] NODE_FREE  = 2'd0;
  localparam logic [1:0] NODE_USED  = 2'd1;
  localparam logic [1:0] NODE_SPLIT = 2'd2;

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_INFO    = 2'd2;

  // result status
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_REFUSED = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;

  // configuration register indexes
  localparam logic REG_TOP_EXP = 1'b0;
  localparam logic REG_USABLE  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_E_STEP,
    OP_READ,
    OP_READ_BUDDY,
    OP_DESC,
    OP_ASC,
    OP_SIB,
    OP_FOUND_A,
    OP_FOUND_R,
    OP_WR_USED,
    OP_WR_SPLIT,
    OP_WR_FREE,
    OP_EMIT_ALLOC,
    OP_EMIT_REL,
    OP_EMIT_REFUSE,
    OP_EMIT_IGNORE,
    OP_EMIT_INFO
  } dp_op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_done;
    logic       alloc_bad;
    logic       rel_bad;
    logic       e_below;
    logic       e_over;
    logic       s_at_top;
    logic       s_at_e;
    logic       s_below_min;
    logic       s_at_min;
    logic       s_zero;
    logic       bit_s;
    logic       misaligned;
    logic       off_beyond;
    logic [1:0] node;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: node state memory, walk registers, byte count and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bba_pkg::dp_op_e             op_i,
  output bba_pkg::dp_sts_t                 sts_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [bba_pkg::SizeW-1:0]   cfg_wdata_i,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [bba_pkg::ReqW-1:0]    request_size_i,
  input  wire logic [bba_pkg::OffW-1:0]    block_offset_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [bba_pkg::OffW-1:0]         result_offset_o,
  output logic [bba_pkg::SizeW-1:0]        block_size_o,
  output logic [bba_pkg::SizeW-1:0]        used_bytes_o,
  output logic [bba_pkg::SizeW-1:0]        free_bytes_o
);
  import bba_pkg::*;

  logic [ExpW-1:0]  top_exp_q;
  logic [SizeW-1:0] usable_q;
  logic [SizeW-1:0] bytes_q, bytes_d;
  logic [IdxW-1:0]  clr_q;
  logic             done_q;

  logic [1:0]       cmd_q;
  logic [ReqW-1:0]  size_q;
  logic [OffW-1:0]  off_q, off_d;
  logic [ExpW-1:0]  s_q, s_d;
  logic [ExpW-1:0]  e_q, e_d;
  logic [OffW-1:0]  res_off_q;
  logic [1:0]       node_q;
  logic [1:0]       status_q;
  logic [OffW-1:0]  out_off_q;
  logic [SizeW-1:0] out_size_q, out_used_q, out_free_q;

  logic [1:0]       mem_q [NodeCnt];
  logic [IdxW-1:0]  mem_addr;
  logic             mem_we, mem_re;
  logic [1:0]       mem_wdata;

  logic [ExpW-1:0]  t;
  logic [SizeW-1:0] free_now;
  logic [SizeW-1:0] pow_s, pow_e;
  logic [SizeW-1:0] off_ext;
  logic [SizeW-1:0] sh_s;
  logic [ReqW:0]    pow_e_wide;
  logic [ReqW-1:0]  add_sum;
  logic             emit;
  logic [1:0]       emit_sts;
  logic [OffW-1:0]  emit_off;
  logic [SizeW-1:0] emit_size;

  function automatic logic [IdxW-1:0] node_idx(input logic [OffW-1:0] off,
                                               input logic [ExpW-1:0] s,
                                               input logic [ExpW-1:0] top);
    logic [SizeW-1:0] sh;
    logic [SizeW-1:0] base;
    logic [SizeW-1:0] sum;
    sh   = {1'b0, off} >> s;
    base = SizeW'(1) << (top - s);
    sum  = sh + base - SizeW'(1);
    return sum[IdxW-1:0];
  endfunction

  function automatic logic [SizeW-1:0] free_of(input logic [SizeW-1:0] usable,
                                               input logic [SizeW-1:0] used);
    return (usable > used) ? (usable - used) : '0;
  endfunction

  // saturate the configured pool exponent
  always_comb begin
    t = top_exp_q;
    if (top_exp_q < ExpW'(MinExp)) begin
      t = ExpW'(MinExp);
    end else if (top_exp_q > ExpW'(MaxExp)) begin
      t = ExpW'(MaxExp);
    end
  end

  assign free_now   = free_of(usable_q, bytes_q);
  assign off_ext    = {1'b0, off_q};
  assign pow_s      = SizeW'(1) << s_q;
  assign pow_e      = SizeW'(1) << e_q;
  assign pow_e_wide = (ReqW+1)'(1) << e_q;
  assign sh_s       = off_ext >> s_q;
  assign add_sum    = {1'b0, bytes_q} + {1'b0, pow_e};

  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.clr_done    = (clr_q == IdxW'(NodeCnt - 1));
    sts_o.alloc_bad   = (size_q == '0) || (size_q > {1'b0, free_now}) ||
                        (size_q > ReqLimit);
    sts_o.rel_bad     = (off_ext >= usable_q) || ((off_ext >> t) != '0);
    sts_o.e_below     = pow_e_wide < {1'b0, size_q};
    sts_o.e_over      = e_q > t;
    sts_o.s_at_top    = (s_q == t);
    sts_o.s_at_e      = (s_q == e_q);
    sts_o.s_below_min = (s_q < ExpW'(MinExp));
    sts_o.s_at_min    = (s_q == ExpW'(MinExp));
    sts_o.s_zero      = (s_q == '0);
    sts_o.bit_s       = sh_s[0];
    sts_o.misaligned  = (off_ext & (pow_s - SizeW'(1))) != '0;
    sts_o.off_beyond  = (off_ext >= usable_q);
    sts_o.node        = node_q;
  end

  // memory port select
  always_comb begin
    mem_addr  = node_idx(off_q, s_q, t);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = NODE_FREE;
    case (op_i)
      OP_CLEAR: begin
        mem_addr = clr_q;
        mem_we   = 1'b1;
      end
      OP_READ: begin
        mem_re = 1'b1;
      end
      OP_READ_BUDDY: begin
        mem_addr = node_idx(off_q ^ pow_s[OffW-1:0], s_q, t);
        mem_re   = 1'b1;
      end
      OP_WR_USED: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_USED;
      end
      OP_WR_SPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = NODE_SPLIT;
      end
      OP_WR_FREE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      node_q <= mem_q[mem_addr];
    end
  end

  // walk registers and result word
  always_comb begin
    off_d     = off_q;
    s_d       = s_q;
    e_d       = e_q;
    bytes_d   = bytes_q;
    emit      = 1'b0;
    emit_sts  = STS_OK;
    emit_off  = '0;
    emit_size = '0;
    case (op_i)
      OP_LOAD: begin
        off_d = (cmd_i == CMD_RELEASE) ? block_offset_i : '0;
        s_d   = t;
        e_d   = ExpW'(MinExp);
      end
      OP_E_STEP: e_d = e_q + ExpW'(1);
      OP_DESC:   s_d = s_q - ExpW'(1);
      OP_ASC: begin
        off_d = off_q & ~pow_s[OffW-1:0];
        s_d   = s_q + ExpW'(1);
      end
      OP_SIB:     off_d = off_q | pow_s[OffW-1:0];
      OP_FOUND_A: s_d = e_q;
      OP_FOUND_R: e_d = s_q;
      OP_EMIT_ALLOC: begin
        bytes_d   = (add_sum > ReqW'({SizeW{1'b1}})) ? {SizeW{1'b1}} : add_sum[SizeW-1:0];
        emit      = 1'b1;
        emit_off  = res_off_q;
        emit_size = pow_e;
      end
      OP_EMIT_REL: begin
        bytes_d   = (bytes_q > pow_e) ? (bytes_q - pow_e) : '0;
        emit      = 1'b1;
        emit_off  = res_off_q;
        emit_size = pow_e;
      end
      OP_EMIT_REFUSE: begin
        emit     = 1'b1;
        emit_sts = STS_REFUSED;
      end
      OP_EMIT_IGNORE: begin
        emit     = 1'b1;
        emit_sts = STS_IGNORED;
      end
      OP_EMIT_INFO: emit = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_exp_q <= ExpW'(MaxExp);
      usable_q  <= SizeW'(1) << MaxExp;
      bytes_q   <= '0;
      clr_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOP_EXP: top_exp_q <= cfg_wdata_i[ExpW-1:0];
          REG_USABLE:  usable_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (op_i == OP_CLEAR) begin
        clr_q <= clr_q + IdxW'(1);
      end
      bytes_q <= bytes_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    s_q   <= s_d;
    e_q   <= e_d;
    if (op_i == OP_LOAD) begin
      cmd_q  <= cmd_i;
      size_q <= request_size_i;
    end
    if (op_i == OP_FOUND_A || op_i == OP_FOUND_R) begin
      res_off_q <= off_q;
    end
    if (emit) begin
      status_q   <= emit_sts;
      out_off_q  <= emit_off;
      out_size_q <= emit_size;
      out_used_q <= bytes_d;
      out_free_q <= free_of(usable_q, bytes_d);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_offset_o = out_off_q;
  assign block_size_o    = out_size_q;
  assign used_bytes_o    = out_used_q;
  assign free_bytes_o    = out_free_q;

endmodule

`default_nettype wire

FILE: rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, left-first tree search, marking, release/merge.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_op_e       op_o,
  output logic                  busy_o
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_AEXP, S_DRD, S_DEVAL, S_ADV, S_MUSED, S_MUP, S_MSPLIT,
    S_RALIGN, S_RLOOP, S_REVAL, S_RFREE, S_MGB, S_MGBE, S_MGP, S_MGPE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_CLR: begin
        op_o = OP_CLEAR;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.cmd)
          CMD_ALLOC: begin
            if (sts_i.alloc_bad) begin
              op_o    = OP_EMIT_REFUSE;
              state_d = S_IDLE;
            end else begin
              state_d = S_AEXP;
            end
          end
          CMD_RELEASE: begin
            if (sts_i.rel_bad) begin
              op_o    = OP_EMIT_IGNORE;
              state_d = S_IDLE;
            end else begin
              state_d = S_RALIGN;
            end
          end
          default: begin
            op_o    = OP_EMIT_INFO;
            state_d = S_IDLE;
          end
        endcase
      end
      // round the request up to a power of two
      S_AEXP: begin
        if (sts_i.e_below) begin
          op_o = OP_E_STEP;
        end else if (sts_i.e_over) begin
          op_o    = OP_EMIT_REFUSE;
          state_d = S_IDLE;
        end else begin
          state_d = S_DRD;
        end
      end
      S_DRD: begin
        op_o    = OP_READ;
        state_d = S_DEVAL;
      end
      // a free node above the target level has an all-free subtree
      S_DEVAL: begin
        if (sts_i.node == NODE_FREE) begin
          if (sts_i.off_beyond) begin
            op_o    = OP_EMIT_REFUSE;
            state_d = S_IDLE;
          end else begin
            op_o    = OP_FOUND_A;
            state_d = S_MUSED;
          end
        end else if (!sts_i.s_at_e && sts_i.node == NODE_SPLIT) begin
          op_o    = OP_DESC;
          state_d = S_DRD;
        end else begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (sts_i.s_at_top) begin
          op_o    = OP_EMIT_REFUSE;
          state_d = S_IDLE;
        end else if (sts_i.bit_s) begin
          op_o = OP_ASC;
        end else begin
          op_o    = OP_SIB;
          state_d = S_DRD;
        end
      end
      S_MUSED: begin
        op_o    = OP_WR_USED;
        state_d = S_MUP;
      end
      S_MUP: begin
        if (sts_i.s_at_top) begin
          op_o    = OP_EMIT_ALLOC;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_ASC;
          state_d = S_MSPLIT;
        end
      end
      S_MSPLIT: begin
        op_o    = OP_WR_SPLIT;
        state_d = S_MUP;
      end
      S_RALIGN: begin
        if (sts_i.misaligned && !sts_i.s_zero) begin
          op_o = OP_DESC;
        end else begin
          state_d = S_RLOOP;
        end
      end
      S_RLOOP: begin
        if (sts_i.s_below_min) begin
          op_o    = OP_EMIT_IGNORE;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_READ;
          state_d = S_REVAL;
        end
      end
      S_REVAL: begin
        if (sts_i.node == NODE_USED) begin
          op_o    = OP_FOUND_R;
          state_d = S_RFREE;
        end else if (sts_i.s_at_min) begin
          op_o    = OP_EMIT_IGNORE;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_DESC;
          state_d = S_RLOOP;
        end
      end
      S_RFREE: begin
        op_o    = OP_WR_FREE;
        state_d = S_MGB;
      end
      S_MGB: begin
        if (sts_i.s_at_top) begin
          op_o    = OP_EMIT_REL;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_READ_BUDDY;
          state_d = S_MGBE;
        end
      end
      S_MGBE: begin
        if (sts_i.node == NODE_FREE) begin
          op_o    = OP_ASC;
          state_d = S_MGP;
        end else begin
          op_o    = OP_EMIT_REL;
          state_d = S_IDLE;
        end
      end
      S_MGP: begin
        op_o    = OP_READ;
        state_d = S_MGPE;
      end
      S_MGPE: begin
        if (sts_i.node == NODE_SPLIT) begin
          op_o    = OP_WR_FREE;
          state_d = S_MGB;
        end else begin
          op_o    = OP_EMIT_REL;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a pool of up to 2^16 bytes, tree of 2-bit node states.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: raise start with cmd_i and its operands; the word is
//    taken at a clock edge where start is high and busy is low. busy stays
//    high until the result is out.
//  - Result channel: done_o pulses for one cycle with status, offset, block
//    size and the used/free byte counts. There is no back-pressure; the
//    receiver must take the word in that cycle.
//  - Config: cfg_we_i writes register cfg_idx_i (0 top exponent, 1 usable
//    size) at once; write only while busy is low.
//  - Allocate rounds the exponent up, then walks the tree: node reads,
//    steps down, sideways or back up, then marks each level up to the top.
//    Release aligns, probes sizes from large to small, then merges level
//    by level. All steps are paced by the single-port node memory.
//  - One command at a time; busy drops with done_o, so the next word can be
//    taken at the edge that ends the done_o cycle.
//  - Reset: a clearing pass writes all 8191 nodes free, with busy high;
//    config writes are still taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [bba_pkg::ReqW-1:0]  request_size_i,
  input  wire logic [bba_pkg::OffW-1:0]  block_offset_i,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [bba_pkg::SizeW-1:0] cfg_wdata_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [bba_pkg::OffW-1:0]       result_offset_o,
  output logic [bba_pkg::SizeW-1:0]      block_size_o,
  output logic [bba_pkg::SizeW-1:0]      used_bytes_o,
  output logic [bba_pkg::SizeW-1:0]      free_bytes_o
);
  import bba_pkg::*;

  dp_op_e  op;
  dp_sts_t sts;

  // sequencer: walks the tree through the single-port node memory
  bba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .op_o   (op),
    .busy_o (busy)
  );

  // node memory, walk position, byte count, result word
  bba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd_i),
    .request_size_i  (request_size_i),
    .block_offset_i  (block_offset_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .block_size_o    (block_size_o),
    .used_bytes_o    (used_bytes_o),
    .free_bytes_o    (free_bytes_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the command/result sequencing and result words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_block_allocator_defines.svh"

module bba_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      done_o,
  input wire logic [1:0]                status_o,
  input wire logic [bba_pkg::OffW-1:0]  result_offset_o,
  input wire logic [bba_pkg::SizeW-1:0] block_size_o
);
  import bba_pkg::*;

  `BBA_ASSERT_NXT(a_take_busy, start && !busy, busy, "command taken but busy low")
  `BBA_ASSERT_IMP(a_done_idle, done_o, !busy, "result while still busy")
  `BBA_ASSERT_IMP(a_fail_zero, done_o && status_o != STS_OK,
                  block_size_o == '0 && result_offset_o == '0, "failed word not zero")
  `BBA_ASSERT_IMP(a_block_pow2, done_o && status_o == STS_OK && block_size_o != '0,
                  $onehot(block_size_o) &&
                  (({1'b0, result_offset_o} & (block_size_o - 1'b1)) == '0),
                  "block size not a power of two or offset misaligned")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .result_offset_o (result_offset_o),
  .block_size_o    (block_size_o)
);

`default_nettype wire

FILE: tb/buddy_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// Self-checking bench for the buddy allocator. A short table of directed
// words is followed by random allocate/release/report traffic under several
// pool settings. Result words are checked against an in-bench model of
// the node tree and byte count, or against words typed into the table.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_tb;
  import bba_pkg::*;

  // cmd 3 is undefined but behaves as a usage report
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int IdleLimit = 200000;  // covers a walk across the whole tree

  typedef struct packed {
    logic [1:0]       sts;
    logic [OffW-1:0]  off;
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] used;
    logic [SizeW-1:0] avail;
  } outcome_t;

  typedef struct {
    logic [1:0] cmd;
    int         req;
    int         off;
    bit         typed;    // expected word typed in below, not predicted
    outcome_t   want;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       cmd_i;
  logic [ReqW-1:0]  request_size_i;
  logic [OffW-1:0]  block_offset_i;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [SizeW-1:0] cfg_wdata_i;
  logic             done_o;
  logic [1:0]       status_o;
  logic [OffW-1:0]  result_offset_o;
  logic [SizeW-1:0] block_size_o;
  logic [SizeW-1:0] used_bytes_o;
  logic [SizeW-1:0] free_bytes_o;

  buddy_block_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .request_size_i, .block_offset_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .status_o, .result_offset_o,
    .block_size_o, .used_bytes_o, .free_bytes_o
  );

  // ---------------- shadow allocator state ----------------
  logic [1:0] pool_tree [NodeCnt];
  int         bytes_held;
  int         top_reg;      // raw 5-bit register, saturated when used
  int         usable_reg;

  outcome_t   expected_words[$];
  int         live_blocks[$];   // offsets granted and not yet released
  row_t       dir_rows[$];
  int         errors;
  int         idle_cycles;

  function automatic int pool_top();
    if (top_reg < MinExp) return MinExp;
    if (top_reg > MaxExp) return MaxExp;
    return top_reg;
  endfunction

  function automatic int avail_bytes();
    return (usable_reg > bytes_held) ? usable_reg - bytes_held : 0;
  endfunction

  function automatic outcome_t pack_word(logic [1:0] s, int o, int z);
    outcome_t w;
    w.sts   = s;
    w.off   = o[OffW-1:0];
    w.size  = z[SizeW-1:0];
    w.used  = bytes_held[SizeW-1:0];
    w.avail = SizeW'(avail_bytes());
    return w;
  endfunction

  // every ancestor must be free or split
  function automatic bit ancestors_open(int n);
    int a;
    a = n;
    while (a != 0) begin
      a = (a - 1) / 2;
      if (pool_tree[a] != NODE_FREE && pool_tree[a] != NODE_SPLIT) return 0;
    end
    return 1;
  endfunction

  function automatic outcome_t grant_block(int req);
    int t, e, first, cnt, n, a, o, bsz;
    t = pool_top();
    e = MinExp;
    if (req == 0 || req > avail_bytes() || req > (1 << 17))
      return pack_word(STS_REFUSED, 0, 0);
    while ((1 << e) < req) e++;
    if (e > t) return pack_word(STS_REFUSED, 0, 0);
    first = (1 << (t - e)) - 1;
    cnt = 1 << (t - e);
    for (int i = 0; i < cnt; i++) begin
      n = first + i;
      if (pool_tree[n] != NODE_FREE || !ancestors_open(n)) continue;
      o = i << e;
      if (o >= usable_reg) break;   // past the usable end: refused, unmarked
      a = n;
      while (a != 0) begin
        a = (a - 1) / 2;
        pool_tree[a] = NODE_SPLIT;
      end
      pool_tree[n] = NODE_USED;
      bsz = 1 << e;
      bytes_held = (bytes_held + bsz > 17'h1FFFF) ? 17'h1FFFF : bytes_held + bsz;
      return pack_word(STS_OK, o, bsz);
    end
    return pack_word(STS_REFUSED, 0, 0);
  endfunction

  function automatic outcome_t free_block(int o);
    int t, e, n, buddy, parent, bsz;
    bit found;
    t = pool_top();
    n = 0;
    found = 0;
    if (o >= usable_reg || o >= (1 << t)) return pack_word(STS_IGNORED, 0, 0);
    e = t;
    while (e > 0 && (o & ((1 << e) - 1)) != 0) e--;
    // largest aligned size first, down to the minimum block
    for (; e >= MinExp; e--) begin
      n = (o >> e) + (1 << (t - e)) - 1;
      if (pool_tree[n] == NODE_USED) begin
        found = 1;
        break;
      end
    end
    if (!found) return pack_word(STS_IGNORED, 0, 0);
    pool_tree[n] = NODE_FREE;
    while (n != 0) begin
      buddy = (n & 1) ? n + 1 : n - 1;
      parent = (n - 1) / 2;
      if (pool_tree[buddy] != NODE_FREE || pool_tree[parent] != NODE_SPLIT) break;
      pool_tree[parent] = NODE_FREE;
      n = parent;
    end
    bsz = 1 << e;
    bytes_held = (bytes_held > bsz) ? bytes_held - bsz : 0;
    return pack_word(STS_OK, o, bsz);
  endfunction

  function automatic outcome_t compute_outcome(logic [1:0] c, int req, int o);
    outcome_t w;
    if (c == CMD_ALLOC) begin
      w = grant_block(req);
      if (w.sts == STS_OK) live_blocks.push_back(int'(w.off));
    end else if (c == CMD_RELEASE) begin
      w = free_block(o);
      if (w.sts == STS_OK)
        foreach (live_blocks[i])
          if (live_blocks[i] == int'(w.off)) begin
            live_blocks.delete(i);
            break;
          end
    end else begin
      w = pack_word(STS_OK, 0, 0);
    end
    return w;
  endfunction

  // ---------------- clock, monitor, watchdog ----------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report("unexpected result word, status", status_o, -1);
      end else begin
        w = expected_words.pop_front();
        if (status_o !== w.sts) report("status", status_o, w.sts);
        if (result_offset_o !== w.off) report("result_offset", result_offset_o, w.off);
        if (block_size_o !== w.size) report("block_size", block_size_o, w.size);
        if (used_bytes_o !== w.used) report("used_bytes", used_bytes_o, w.used);
        if (free_bytes_o !== w.avail) report("free_bytes", free_bytes_o, w.avail);
      end
    end
    // watchdog: any accepted word on either side restarts the count
    if (done_o || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- driver tasks (called at a falling edge) ----------------
  // Drives one command word; gap > 0 then drops start for the gap.
  task automatic send(logic [1:0] c, int req, int o, int gap, bit typed, outcome_t want);
    outcome_t w;
    start          <= 1'b1;
    cmd_i          <= c;
    request_size_i <= req[ReqW-1:0];
    block_offset_i <= o[OffW-1:0];
    do @(posedge clk_i); while (busy);
    w = compute_outcome(c, req, o);
    expected_words.push_back(typed ? want : w);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // wait until every expected word is in and the block is idle
  task automatic drain();
    while (expected_words.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic set_pool(int top, int usable);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TOP_EXP;
    cfg_wdata_i <= top[SizeW-1:0];
    @(negedge clk_i);
    cfg_idx_i   <= REG_USABLE;
    cfg_wdata_i <= usable[SizeW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    top_reg    = top & 5'h1F;
    usable_reg = usable & 17'h1FFFF;
  endtask

  function automatic void add_row(logic [1:0] c, int req, int o, bit typed,
                                  logic [1:0] s, int ro, int z, int u, int f);
    row_t r;
    r.cmd = c; r.req = req; r.off = o; r.typed = typed;
    r.want.sts = s; r.want.off = ro[OffW-1:0]; r.want.size = z[SizeW-1:0];
    r.want.used = u[SizeW-1:0]; r.want.avail = f[SizeW-1:0];
    dir_rows.push_back(r);
  endfunction

  // random request size, weighted toward blocks that fit the pool
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 1 << $urandom_range(0, pool_top()));
    if (r < 85) return $urandom_range(1, 64);
    if (r < 95) return $urandom & 18'h3FFFF;
    if (r < 98) return 1 << $urandom_range(MinExp, 17);
    return 0;
  endfunction

  function automatic int pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (live_blocks.size() != 0 && r < 75)
      return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    if (live_blocks.size() != 0 && r < 85)   // inside a block over 16 bytes
      return (live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 16) & 16'hFFFF;
    return $urandom & 16'hFFFF;
  endfunction

  // ---------------- stimulus ----------------
  initial begin
    outcome_t none;
    int pools[7][2];
    int burst, gap, r, n;
    logic [1:0] c;
    none = '0;
    errors = 0;
    idle_cycles = 0;
    start = 1'b0; cmd_i = CMD_INFO; request_size_i = '0; block_offset_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = REG_TOP_EXP; cfg_wdata_i = '0;
    foreach (pool_tree[i]) pool_tree[i] = NODE_FREE;
    bytes_held = 0; top_reg = 16; usable_reg = 65536;

    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // clearing pass keeps busy high; just wait it out
    drain();

    // directed table at reset settings
    add_row(CMD_INFO,    0,      0,     1, STS_OK,      0,  0,     0,     65536);
    add_row(CMD_ALLOC,   0,      0,     1, STS_REFUSED, 0,  0,     0,     65536);
    add_row(CMD_ALLOC,   262143, 65535, 1, STS_REFUSED, 0,  0,     0,     65536);
    add_row(CMD_ALLOC,   131073, 0,     1, STS_REFUSED, 0,  0,     0,     65536);
    add_row(CMD_ALLOC,   1,      0,     1, STS_OK,      0,  16,    16,    65520);
    add_row(CMD_ALLOC,   17,     0,     1, STS_OK,      32, 32,    48,    65488);
    add_row(CMD_RELEASE, 0,      0,     1, STS_OK,      0,  16,    32,    65504);
    add_row(CMD_RELEASE, 0,      0,     1, STS_IGNORED, 0,  0,     32,    65504);
    add_row(CMD_RELEASE, 0,      65535, 1, STS_IGNORED, 0,  0,     32,    65504);
    add_row(CMD_RELEASE, 0,      32,    1, STS_OK,      32, 32,    0,     65536);
    add_row(CMD_ALLOC,   65536,  0,     1, STS_OK,      0,  65536, 65536, 0);
    add_row(CMD_ALLOC,   16,     0,     1, STS_REFUSED, 0,  0,     65536, 0);
    add_row(CMD_RELEASE, 0,      0,     1, STS_OK,      0,  65536, 0,     65536);
    add_row(CMD_SPARE,   262143, 65535, 1, STS_OK,      0,  0,     0,     65536);
    add_row(CMD_ALLOC,   40000,  0,     0, STS_OK, 0, 0, 0, 0);
    add_row(CMD_RELEASE, 0,      16,    0, STS_OK, 0, 0, 0, 0);   // mid-block
    add_row(CMD_RELEASE, 0,      0,     0, STS_OK, 0, 0, 0, 0);
    add_row(CMD_ALLOC,   16,     0,     0, STS_OK, 0, 0, 0, 0);
    add_row(CMD_ALLOC,   4096,   0,     0, STS_OK, 0, 0, 0, 0);
    add_row(CMD_RELEASE, 0,      4096,  0, STS_OK, 0, 0, 0, 0);
    add_row(CMD_RELEASE, 0,      0,     0, STS_OK, 0, 0, 0, 0);
    foreach (dir_rows[i])
      send(dir_rows[i].cmd, dir_rows[i].req, dir_rows[i].off, i % 3,
           dir_rows[i].typed, dir_rows[i].want);
    drain();

    // pool settings: extremes, saturated exponents, short usable ends
    pools = '{'{4, 16}, '{0, 100}, '{31, 131071}, '{10, 700},
              '{7, 96}, '{16, 40000}, '{16, 65536}};
    foreach (pools[p]) begin
      set_pool(pools[p][0], pools[p][1]);
      n = 0;
      while (n < 110) begin
        burst = $urandom_range(1, 10);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        for (int b = 0; b < burst && n < 110; b++) begin
          r = $urandom_range(0, 99);
          c = (r < 50) ? CMD_ALLOC : (r < 88) ? CMD_RELEASE :
              (r < 95) ? CMD_INFO : CMD_SPARE;
          send(c, (c == CMD_ALLOC) ? pick_size() : ($urandom & 18'h3FFFF),
               (c == CMD_RELEASE) ? pick_offset() : ($urandom & 16'hFFFF),
               (b == burst - 1) ? gap : 0, 0, none);
          n++;
        end
        // occasionally hold off until everything has come back
        if ($urandom_range(0, 15) == 0) begin
          if (start) begin
            start <= 1'b0;
            @(negedge clk_i);
          end
          drain();
        end
      end
      // hand back what is still held so the next pool starts clean
      while (live_blocks.size() != 0)
        send(CMD_RELEASE, 0, live_blocks[0], $urandom_range(0, 2), 0, none);
      if (start) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_dp.sv
rtl/core/bba_ctrl.sv
rtl/core/buddy_block_allocator.sv
rtl/core/bba_checker.sv
tb/buddy_block_allocator_tb.sv
